/* hw/rtl/rect_overlap_ratio_assert.svh */
// ---------------------------------------------------------------------------
// rect_overlap_ratio_assert.svh: assertion macros
// Shared concurrent assertion forms for the overlap ratio checker.
// ---------------------------------------------------------------------------
`ifndef RECT_OVERLAP_RATIO_ASSERT_SVH
`define RECT_OVERLAP_RATIO_ASSERT_SVH

// ante implies cons at the same edge
`define ROR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ror implication failed");

// a stalled item keeps valid high and its payload unchanged
`define ROR_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) \
		((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
		else $error("ror stalled item changed");

`endif

/* hw/rtl/ror_pkg.sv */
// ---------------------------------------------------------------------------
// ror_pkg: rectangle overlap ratio package
// Widths, mode codes and the item type passed from front to back.
// ---------------------------------------------------------------------------
package ror_pkg;

	localparam int COORD_W         = 16;
	localparam int MODE_W          = 2;
	localparam int AREA_W          = 2 * COORD_W;
	localparam int DEN_W           = AREA_W + 1;
	localparam int RATIO_FRAC_BITS = 16;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [MODE_W-1:0] MODE_UNION   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SMALLER = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LARGER  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

	typedef enum logic [1:0] {
		KIND_DIVIDE,
		KIND_ZERO_DEN,
		KIND_NONE
	} kind_t;

	typedef struct packed {
		logic [AREA_W-1:0] num;
		logic [DEN_W-1:0]  den;
		kind_t             kind;
	} item_t;

endpackage

/* hw/rtl/ror_in_if.sv */
// ---------------------------------------------------------------------------
// ror_in_if: rectangle pair channel
// Valid/ready channel carrying two rectangles and a ratio mode.
// ---------------------------------------------------------------------------
interface ror_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [ror_pkg::COORD_W-1:0] first_left;
	logic signed [ror_pkg::COORD_W-1:0] first_top;
	logic        [ror_pkg::COORD_W-1:0] first_width;
	logic        [ror_pkg::COORD_W-1:0] first_height;
	logic signed [ror_pkg::COORD_W-1:0] second_left;
	logic signed [ror_pkg::COORD_W-1:0] second_top;
	logic        [ror_pkg::COORD_W-1:0] second_width;
	logic        [ror_pkg::COORD_W-1:0] second_height;
	logic        [ror_pkg::MODE_W-1:0]  mode;

	modport source (
		output valid, first_left, first_top, first_width, first_height,
		output second_left, second_top, second_width, second_height, mode,
		input  ready
	);

	modport sink (
		input  valid, first_left, first_top, first_width, first_height,
		input  second_left, second_top, second_width, second_height, mode,
		output ready
	);
endinterface

/* hw/rtl/ror_out_if.sv */
// ---------------------------------------------------------------------------
// ror_out_if: overlap ratio result channel
// Valid/ready channel carrying the ratio and the zero denominator flag.
// ---------------------------------------------------------------------------
interface ror_out_if #(
	parameter int RATIO_FRAC_BITS = ror_pkg::RATIO_FRAC_BITS
);
	logic                     valid;
	logic                     ready;
	logic [RATIO_FRAC_BITS:0] ratio;
	logic                     zero_denominator;

	modport source (
		output valid, ratio, zero_denominator,
		input  ready
	);

	modport sink (
		input  valid, ratio, zero_denominator,
		output ready
	);
endinterface

/* hw/rtl/ror_front.sv */
// ---------------------------------------------------------------------------
// ror_front: overlap front end
// Four-stage pipeline: span edges, overlap lengths, areas, then the
// denominator and item kind for the divider.
// ---------------------------------------------------------------------------
module ror_front (
	input  logic           clk,
	input  logic           arst_n,
	ror_in_if.sink         pair,
	output logic           item_valid,
	input  logic           item_ready,
	output ror_pkg::item_t item
);
	localparam int CW = ror_pkg::COORD_W;
	localparam int EW = CW + 2;
	localparam int AW = ror_pkg::AREA_W;
	localparam int DW = ror_pkg::DEN_W;

	logic adv;

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic signed [EW-1:0] lo_x_s1, lo_y_s1, end1_x_s1, end2_x_s1, end1_y_s1, end2_y_s1;
	logic [CW-1:0]        w1_s1, h1_s1, w2_s1, h2_s1;
	logic [CW-1:0]        w1_s2, h1_s2, w2_s2, h2_s2;
	logic [ror_pkg::MODE_W-1:0] mode_s1, mode_s2, mode_s3;
	logic [CW-1:0]        ov_x_s2, ov_y_s2;
	logic [AW-1:0]        a1_s3, a2_s3, a3_s3;
	ror_pkg::item_t       item_s4;

	logic signed [EW-1:0] l1, l2, t1, t2, e1x, e2x, e1y, e2y;
	logic signed [EW-1:0] hi_x, hi_y, dx, dy;
	logic [DW-1:0]        uni, amin, amax, den;
	ror_pkg::item_t       item_d;

	assign adv        = !v_s4 || item_ready;
	assign pair.ready = adv;
	assign item_valid = v_s4;
	assign item       = item_s4;

	always_comb begin
		l1  = {{2{pair.first_left[CW-1]}}, pair.first_left};
		l2  = {{2{pair.second_left[CW-1]}}, pair.second_left};
		t1  = {{2{pair.first_top[CW-1]}}, pair.first_top};
		t2  = {{2{pair.second_top[CW-1]}}, pair.second_top};
		e1x = l1 + $signed({2'b00, pair.first_width});
		e2x = l2 + $signed({2'b00, pair.second_width});
		e1y = t1 + $signed({2'b00, pair.first_height});
		e2y = t2 + $signed({2'b00, pair.second_height});
	end

	always_comb begin
		hi_x = (end1_x_s1 < end2_x_s1) ? end1_x_s1 : end2_x_s1;
		hi_y = (end1_y_s1 < end2_y_s1) ? end1_y_s1 : end2_y_s1;
		dx   = hi_x - lo_x_s1;
		dy   = hi_y - lo_y_s1;
	end

	always_comb begin
		uni  = {1'b0, a1_s3} + {1'b0, a2_s3} - {1'b0, a3_s3};
		amin = (a1_s3 < a2_s3) ? {1'b0, a1_s3} : {1'b0, a2_s3};
		amax = (a1_s3 < a2_s3) ? {1'b0, a2_s3} : {1'b0, a1_s3};
		den  = '0;
		unique case (mode_s3)
			ror_pkg::MODE_UNION:   den = uni;
			ror_pkg::MODE_SMALLER: den = amin;
			ror_pkg::MODE_LARGER:  den = amax;
			default:               den = '0;
		endcase
		item_d.num  = a3_s3;
		item_d.den  = den;
		if (mode_s3 == ror_pkg::MODE_NONE) begin
			item_d.kind = ror_pkg::KIND_NONE;
		end else if (den == '0) begin
			item_d.kind = ror_pkg::KIND_ZERO_DEN;
		end else begin
			item_d.kind = ror_pkg::KIND_DIVIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pair.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_x_s1   <= (l1 > l2) ? l1 : l2;
			lo_y_s1   <= (t1 > t2) ? t1 : t2;
			end1_x_s1 <= e1x;
			end2_x_s1 <= e2x;
			end1_y_s1 <= e1y;
			end2_y_s1 <= e2y;
			w1_s1     <= pair.first_width;
			h1_s1     <= pair.first_height;
			w2_s1     <= pair.second_width;
			h2_s1     <= pair.second_height;
			mode_s1   <= pair.mode;

			ov_x_s2   <= (hi_x > lo_x_s1) ? dx[CW-1:0] : '0;
			ov_y_s2   <= (hi_y > lo_y_s1) ? dy[CW-1:0] : '0;
			w1_s2     <= w1_s1;
			h1_s2     <= h1_s1;
			w2_s2     <= w2_s1;
			h2_s2     <= h2_s1;
			mode_s2   <= mode_s1;

			a1_s3     <= w1_s2 * h1_s2;
			a2_s3     <= w2_s2 * h2_s2;
			a3_s3     <= ov_x_s2 * ov_y_s2;
			mode_s3   <= mode_s2;

			item_s4   <= item_d;
		end
	end
endmodule

/* hw/rtl/ror_queue.sv */
// ---------------------------------------------------------------------------
// ror_queue: front-to-back item queue
// Small register FIFO that lets the front and the divider stall apart.
// ---------------------------------------------------------------------------
module ror_queue #(
	parameter int DEPTH = ror_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  ror_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output ror_pkg::item_t pop_item
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0]  LAST = PW'(DEPTH - 1);
	localparam logic [CNW-1:0] FULL = CNW'(DEPTH);

	ror_pkg::item_t entries_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNW-1:0] count_q;
	logic           do_push, do_pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end
endmodule

/* hw/rtl/ror_divider.sv */
// ---------------------------------------------------------------------------
// ror_divider: pipelined restoring divider
// One quotient bit per stage; the last stage is the output register.
// ---------------------------------------------------------------------------
module ror_divider #(
	parameter int RATIO_FRAC_BITS = ror_pkg::RATIO_FRAC_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  ror_pkg::item_t item,
	ror_out_if.source      result
);
	localparam int Q  = RATIO_FRAC_BITS + 1;
	localparam int DW = ror_pkg::DEN_W;

	logic            adv;
	logic            v_sn    [Q];
	logic [DW-1:0]   rem_sn  [Q];
	logic [DW-1:0]   den_sn  [Q];
	logic [Q-1:0]    quo_sn  [Q];
	ror_pkg::kind_t  kind_sn [Q];

	assign adv        = !v_sn[Q-1] || result.ready;
	assign item_ready = adv;

	assign result.valid            = v_sn[Q-1];
	assign result.ratio            = (kind_sn[Q-1] == ror_pkg::KIND_DIVIDE) ? quo_sn[Q-1] : '0;
	assign result.zero_denominator = (kind_sn[Q-1] == ror_pkg::KIND_ZERO_DEN);

	for (genvar gi = 0; gi < Q; gi++) begin : g_stage
		logic           v_in;
		logic [DW-1:0]  rem_in, den_in;
		logic [Q-1:0]   quo_in;
		ror_pkg::kind_t kind_in;
		logic [DW:0]    trial, diff;
		logic           ge;

		if (gi == 0) begin : g_first
			assign v_in    = item_valid;
			assign rem_in  = {1'b0, item.num};
			assign den_in  = item.den;
			assign quo_in  = '0;
			assign kind_in = item.kind;
			assign trial   = {1'b0, rem_in};
		end else begin : g_next
			assign v_in    = v_sn[gi-1];
			assign rem_in  = rem_sn[gi-1];
			assign den_in  = den_sn[gi-1];
			assign quo_in  = quo_sn[gi-1];
			assign kind_in = kind_sn[gi-1];
			assign trial   = {rem_in, 1'b0};
		end

		assign diff = trial - {1'b0, den_in};
		assign ge   = (trial >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[gi] <= 1'b0;
			end else if (adv) begin
				v_sn[gi] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sn[gi]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				den_sn[gi]  <= den_in;
				quo_sn[gi]  <= {quo_in[Q-2:0], ge};
				kind_sn[gi] <= kind_in;
			end
		end
	end
endmodule

/* hw/rtl/rect_overlap_ratio.sv */
// ---------------------------------------------------------------------------
// rect_overlap_ratio: rectangle overlap ratio
// Intersection over union, over the smaller or over the larger area.
// ---------------------------------------------------------------------------
// Takes one rectangle pair per cycle and returns one result per pair, in
// order, at a sustained rate of one item per clock while the result side
// does not stall. Four front stages form the areas and the denominator, the
// queue registers each item, and a pipelined restoring divider with one
// stage per quotient bit forms the ratio. A queue of QUEUE_DEPTH items
// between them keeps the input side taking items while a result waits,
// until the queue is full.
// Mode three gives ratio 0, a zero denominator gives ratio 0 with the flag set.
module rect_overlap_ratio #(
	parameter int RATIO_FRAC_BITS = ror_pkg::RATIO_FRAC_BITS,
	parameter int QUEUE_DEPTH     = ror_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	ror_in_if.sink    pair,
	ror_out_if.source result
);
	logic           f_valid, f_ready, b_valid, b_ready;
	ror_pkg::item_t f_item, b_item;

	ror_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair       (pair),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	ror_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_item   (b_item)
	);

	ror_divider #(
		.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
	) u_divider (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (b_valid),
		.item_ready (b_ready),
		.item       (b_item),
		.result     (result)
	);
endmodule

/* hw/rtl/ror_checker.sv */
// ---------------------------------------------------------------------------
// ror_checker: result port checks
// Watches the result channel of the overlap ratio block.
// ---------------------------------------------------------------------------
`include "rect_overlap_ratio_assert.svh"

module ror_checker #(
	parameter int RATIO_FRAC_BITS = ror_pkg::RATIO_FRAC_BITS
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     res_valid,
	input logic                     res_ready,
	input logic [RATIO_FRAC_BITS:0] ratio,
	input logic                     zero_denominator
);
	localparam logic [RATIO_FRAC_BITS:0] ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};

	logic [RATIO_FRAC_BITS+1:0] res_payload;

	assign res_payload = {ratio, zero_denominator};

	`ROR_ASSERT_HOLD(a_hold, clk, arst_n, res_valid, res_ready, res_payload)
	`ROR_ASSERT_IMPLY(a_range, clk, arst_n, res_valid, ratio <= ONE)
	`ROR_ASSERT_IMPLY(a_flag_zero, clk, arst_n, res_valid && zero_denominator, ratio == '0)
	`ROR_ASSERT_IMPLY(a_reset, clk, 1'b1, !arst_n, !res_valid)
endmodule

bind rect_overlap_ratio ror_checker #(
	.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
) u_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (result.valid),
	.res_ready        (result.ready),
	.ratio            (result.ratio),
	.zero_denominator (result.zero_denominator)
);

/* tb/rect_overlap_ratio_test.sv */
// ---------------------------------------------------------------------------
// rect_overlap_ratio_test: overlap ratio testbench
// Sends rectangle pairs through the valid/ready input channel and checks
// every result against a predictor of the intersection, union, smaller and
// larger areas. Covers corner cases, random pairs under both idling
// patterns and at full rate, and a long result-side hold-off.
// ---------------------------------------------------------------------------
module rect_overlap_ratio_test;
	import ror_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		logic signed [COORD_W-1:0] first_left;
		logic signed [COORD_W-1:0] first_top;
		logic        [COORD_W-1:0] first_width;
		logic        [COORD_W-1:0] first_height;
		logic signed [COORD_W-1:0] second_left;
		logic signed [COORD_W-1:0] second_top;
		logic        [COORD_W-1:0] second_width;
		logic        [COORD_W-1:0] second_height;
		logic        [MODE_W-1:0]  mode;
	} rect_pair_t;

	typedef struct {
		logic [RATIO_FRAC_BITS:0] ratio;
		logic                     zero_denominator;
	} overlap_t;

	logic clk;
	logic arst_n;

	ror_in_if  pair ();
	ror_out_if result ();

	rect_overlap_ratio u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair),
		.result (result)
	);

	overlap_t expected_ratios[$];
	int       mismatches = 0;
	int       send_idle_pct = 0;
	int       sink_idle_pct = 0;
	int       hold_asks = 0;
	int       hold_seen = 0;
	int       hold_left = 0;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic longint unsigned span_len(logic signed [COORD_W-1:0] a0,
			logic [COORD_W-1:0] al, logic signed [COORD_W-1:0] b0,
			logic [COORD_W-1:0] bl);
		longint lo, hi, ae, be;
		lo = (longint'(a0) > longint'(b0)) ? longint'(a0) : longint'(b0);
		ae = longint'(a0) + longint'(al);
		be = longint'(b0) + longint'(bl);
		hi = (ae < be) ? ae : be;
		return (hi > lo) ? longint'(hi - lo) : 64'd0;
	endfunction

	function automatic overlap_t predict_overlap(rect_pair_t p);
		longint unsigned area1, area2, common, den;
		overlap_t r;
		area1 = {48'd0, p.first_width} * {48'd0, p.first_height};
		area2 = {48'd0, p.second_width} * {48'd0, p.second_height};
		common = span_len(p.first_left, p.first_width, p.second_left, p.second_width) *
			span_len(p.first_top, p.first_height, p.second_top, p.second_height);
		den = 0;
		r.ratio = '0;
		r.zero_denominator = 1'b0;
		case (p.mode)
			MODE_UNION: den = area1 + area2 - common;
			MODE_SMALLER: den = (area1 < area2) ? area1 : area2;
			MODE_LARGER: den = (area1 > area2) ? area1 : area2;
			default: den = 0;
		endcase
		if (p.mode != MODE_NONE) begin
			if (den == 0)
				r.zero_denominator = 1'b1;
			else
				r.ratio = (RATIO_FRAC_BITS+1)'((common << RATIO_FRAC_BITS) / den);
		end
		return r;
	endfunction

	function automatic rect_pair_t make_pair(int l1, int t1, int w1, int h1,
			int l2, int t2, int w2, int h2, logic [MODE_W-1:0] m);
		rect_pair_t p;
		p.first_left = COORD_W'(l1);
		p.first_top = COORD_W'(t1);
		p.first_width = COORD_W'(w1);
		p.first_height = COORD_W'(h1);
		p.second_left = COORD_W'(l2);
		p.second_top = COORD_W'(t2);
		p.second_width = COORD_W'(w2);
		p.second_height = COORD_W'(h2);
		p.mode = m;
		return p;
	endfunction

	function automatic rect_pair_t random_pair();
		rect_pair_t p;
		int shape;
		shape = $urandom_range(0, 9);
		p.first_left = COORD_W'($urandom);
		p.first_top = COORD_W'($urandom);
		p.first_width = COORD_W'($urandom);
		p.first_height = COORD_W'($urandom);
		p.second_left = COORD_W'($urandom);
		p.second_top = COORD_W'($urandom);
		p.second_width = COORD_W'($urandom);
		p.second_height = COORD_W'($urandom);
		case (shape)
			2, 3, 4: begin
				p.first_left = COORD_W'(int'($urandom_range(0, 4095)) - 2048);
				p.first_top = COORD_W'(int'($urandom_range(0, 4095)) - 2048);
				p.first_width = COORD_W'($urandom_range(0, 2048));
				p.first_height = COORD_W'($urandom_range(0, 2048));
				p.second_left = p.first_left + COORD_W'(int'($urandom_range(0, 2048)) - 1024);
				p.second_top = p.first_top + COORD_W'(int'($urandom_range(0, 2048)) - 1024);
				p.second_width = COORD_W'($urandom_range(0, 2048));
				p.second_height = COORD_W'($urandom_range(0, 2048));
			end
			5, 6: begin
				p.second_left = p.first_left + COORD_W'(int'($urandom_range(0, 8191)) - 4096);
				p.second_top = p.first_top + COORD_W'(int'($urandom_range(0, 8191)) - 4096);
			end
			7: begin
				if ($urandom_range(0, 1)) p.first_width = '0;
				if ($urandom_range(0, 1)) p.first_height = '0;
				if ($urandom_range(0, 1)) p.second_width = '0;
				if ($urandom_range(0, 1)) p.second_height = '0;
			end
			8: begin
				p.second_left = p.first_left + COORD_W'($urandom_range(0, 3));
				p.second_top = p.first_top + COORD_W'($urandom_range(0, 3));
				p.second_width = p.first_width >> $urandom_range(0, 3);
				p.second_height = p.first_height >> $urandom_range(0, 3);
			end
			9: begin
				p.second_left = p.first_left + p.first_width;
				p.second_top = p.first_top + COORD_W'($urandom_range(0, 255));
			end
			default: ;
		endcase
		p.mode = MODE_W'($urandom_range(0, 3));
		return p;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $time);
		mismatches++;
	endtask

	// Called right after a falling edge; returns right after a falling edge.
	task automatic send_pair(rect_pair_t p);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pair.valid <= 1'b0;
			@(negedge clk);
		end
		pair.valid <= 1'b1;
		pair.first_left <= p.first_left;
		pair.first_top <= p.first_top;
		pair.first_width <= p.first_width;
		pair.first_height <= p.first_height;
		pair.second_left <= p.second_left;
		pair.second_top <= p.second_top;
		pair.second_width <= p.second_width;
		pair.second_height <= p.second_height;
		pair.mode <= p.mode;
		do
			@(posedge clk);
		while (!pair.ready);
		expected_ratios.push_back(predict_overlap(p));
		@(negedge clk);
	endtask

	initial begin
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result.ready <= 1'b0;
				hold_left--;
			end else begin
				result.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		overlap_t want;
		if (arst_n && result.valid && result.ready) begin
			if (expected_ratios.size() == 0) begin
				report_mismatch("unexpected result ratio", result.ratio, -1);
			end else begin
				want = expected_ratios.pop_front();
				if (result.ratio !== want.ratio)
					report_mismatch("ratio", result.ratio, want.ratio);
				if (result.zero_denominator !== want.zero_denominator)
					report_mismatch("zero_denominator", result.zero_denominator,
						want.zero_denominator);
			end
		end
	end

	task automatic test_corner_cases();
		send_idle_pct = 30;
		sink_idle_pct = 30;
		// zero areas under every mode
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, MODE_UNION));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, MODE_SMALLER));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, MODE_LARGER));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, MODE_NONE));
		// identical rectangles, full overlap
		send_pair(make_pair(-160, 320, 800, 480, -160, 320, 800, 480, MODE_UNION));
		send_pair(make_pair(-160, 320, 800, 480, -160, 320, 800, 480, MODE_NONE));
		// largest rectangles at the coordinate extremes
		send_pair(make_pair(-32768, -32768, 65535, 65535, -32768, -32768, 65535, 65535,
			MODE_UNION));
		send_pair(make_pair(32767, 32767, 65535, 65535, 32767, 32767, 65535, 65535,
			MODE_LARGER));
		send_pair(make_pair(-32768, -32768, 65535, 65535, 32767, 32767, 65535, 65535,
			MODE_SMALLER));
		send_pair(make_pair(-32768, -32768, 65535, 65535, 32767, 32767, 1, 1, MODE_UNION));
		// contained rectangle
		send_pair(make_pair(0, 0, 1000, 1000, 100, 100, 200, 300, MODE_SMALLER));
		send_pair(make_pair(0, 0, 1000, 1000, 100, 100, 200, 300, MODE_LARGER));
		send_pair(make_pair(0, 0, 1000, 1000, 100, 100, 200, 300, MODE_UNION));
		// edges that only touch
		send_pair(make_pair(0, 0, 16, 16, 16, 0, 16, 16, MODE_UNION));
		send_pair(make_pair(0, 0, 16, 16, 0, -16, 16, 16, MODE_SMALLER));
		// far apart
		send_pair(make_pair(-32768, -32768, 1, 1, 32767, 32767, 65535, 65535, MODE_LARGER));
		// one side zero sized
		send_pair(make_pair(10, 10, 0, 500, 0, 0, 100, 100, MODE_SMALLER));
		send_pair(make_pair(10, 10, 0, 500, 0, 0, 100, 100, MODE_LARGER));
		send_pair(make_pair(10, 10, 0, 500, 0, 0, 100, 100, MODE_UNION));
		// partial overlap with negative corners
		send_pair(make_pair(-500, -300, 700, 400, -100, -250, 900, 1000, MODE_UNION));
		send_pair(make_pair(-500, -300, 700, 400, -100, -250, 900, 1000, MODE_SMALLER));
		send_pair(make_pair(-500, -300, 700, 400, -100, -250, 900, 1000, MODE_LARGER));
		send_pair(make_pair(-500, -300, 700, 400, -100, -250, 900, 1000, MODE_NONE));
		// partial overlap giving a ratio of one half
		send_pair(make_pair(0, 0, 3, 1, 1, 0, 3, 1, MODE_UNION));
	endtask

	task automatic run_random(int count, int send_pct, int sink_pct);
		send_idle_pct = send_pct;
		sink_idle_pct = sink_pct;
		repeat (count) send_pair(random_pair());
	endtask

	task automatic test_receiver_slow();
		run_random(560, 14, 83);
	endtask

	task automatic test_sender_slow();
		run_random(560, 83, 14);
	endtask

	task automatic test_full_rate();
		run_random(560, 0, 0);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		sink_idle_pct = 0;
		hold_asks++;
		repeat (140) send_pair(random_pair());
	endtask

	initial begin
		arst_n = 1'b0;
		pair.valid = 1'b0;
		pair.first_left = '0;
		pair.first_top = '0;
		pair.first_width = '0;
		pair.first_height = '0;
		pair.second_left = '0;
		pair.second_top = '0;
		pair.second_width = '0;
		pair.second_height = '0;
		pair.mode = MODE_UNION;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_corner_cases();
		test_receiver_slow();
		test_sender_slow();
		test_full_rate();
		test_backpressure();

		pair.valid <= 1'b0;
		sink_idle_pct = 0;
		while (expected_ratios.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
